// ===== hdl/video_register_port_assert.svh =====
// ----------------------------------------------------------------------------
// video_register_port_assert.svh
// Assertion macros shared by the video register port RTL.
// ----------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_ASSERT_SVH
`define VIDEO_REGISTER_PORT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define VRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define VRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Types and constants of the video register port.
// ----------------------------------------------------------------------------
package vrp_pkg;

  // Store sizes and address widths
  localparam int SPR_BYTES = 256;
  localparam int NT_BYTES  = 2048;
  localparam int PAT_BYTES = 8192;
  localparam int PAL_BYTES = 32;
  localparam int SPR_AW    = $clog2(SPR_BYTES);
  localparam int NT_AW     = $clog2(NT_BYTES);
  localparam int PAT_AW    = $clog2(PAT_BYTES);
  localparam int PAL_AW    = $clog2(PAL_BYTES);
  localparam int VA_W      = 14;
  localparam int VADDR_W   = 15;

  // Video address map
  localparam logic [VA_W-1:0] PAT_LAST       = 14'h1FFF;
  localparam logic [VA_W-1:0] PAL_BASE       = 14'h3F00;
  localparam logic [VA_W-1:0] NT_MIRROR_MASK = 14'h2FFF;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_VBL_SET = 2'd2,
    OP_VBL_CLR = 2'd3
  } vrp_op_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_SPR_ADDR = 3'd3,
    REG_SPR_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } vrp_reg_t;

  typedef struct packed {
    vrp_op_t    opcode;
    vrp_reg_t   reg_select;
    logic [7:0] write_data;
  } vrp_in_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic [VADDR_W-1:0] current_addr;
    logic [VADDR_W-1:0] temp_addr;
    logic [2:0]         fine_scroll_x;
    logic [7:0]         control_value;
    logic [7:0]         mask_value;
    logic               vblank_flag;
    logic               second_write;
  } vrp_out_t;

  typedef struct packed {
    logic mirror_vertical;
  } vrp_cfg_t;

  // Request from the register logic to the video memory
  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [VA_W-1:0] addr;
    logic [7:0]      wdata;
    logic            mirror_vertical;
  } vrp_vram_req_t;

endpackage

// ===== hdl/vrp_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface vrp_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/video_register_port.sv =====
`timescale 1ns / 1ps
// Output: a result appears in the output register in the cycle after its item transfers.
// Throughput: one item per cycle; the input side stalls while a result waits unread or the clear sweep runs.
// Reset: synchronous, active low; control registers, palette and sprite valid bits clear at once.
// After reset a sweep zeroes pattern and nametable RAM (one entry per cycle); no item is
// taken during it, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// video_register_port
// CPU-side register port of a tile video processor: control, mask, status,
// scroll/address latches, sprite memory, palette and video memory access.
// ----------------------------------------------------------------------------
`include "video_register_port_assert.svh"

module video_register_port
  import vrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  vrp_chan_if.sink    in_ch,
  vrp_chan_if.source  out_ch,
  vrp_chan_if.sink    cfg_ch
);

  // Architectural registers
  logic [7:0]         ctrl_r,       ctrl_nxt;
  logic [7:0]         mask_r,       mask_nxt;
  logic               vblank_r,     vblank_nxt;
  logic               toggle_r,     toggle_nxt;
  logic [VADDR_W-1:0] tmp_r,        tmp_nxt;
  logic [VADDR_W-1:0] cur_r,        cur_nxt;
  logic [2:0]         fine_x_r,     fine_x_nxt;
  logic [SPR_AW-1:0]  spr_addr_r,   spr_addr_nxt;
  logic [7:0]         bus_r,        bus_nxt;
  logic               mirror_r;

  // Stores
  logic [7:0]           pal_r [PAL_BYTES];
  logic [7:0]           spr_mem [SPR_BYTES];
  logic [SPR_BYTES-1:0] spr_vld_r;
  logic [7:0]           spr_q_r;
  logic                 spr_ok_r;

  // Output register
  vrp_out_t out_r, out_nxt;
  logic     out_valid_r;

  logic               in_acc;
  logic               vram_busy;
  logic [7:0]         vram_rdata;
  vrp_vram_req_t      vreq;
  logic [VA_W-1:0]    vaddr;
  logic               pal_hit;
  logic [PAL_AW-1:0]  pal_idx;
  logic               pal_we;
  logic               spr_we;
  logic [7:0]         spr_rdata;
  logic [VADDR_W-1:0] cur_inc;
  vrp_reg_t           sel;
  logic [7:0]         d;

  // Palette entries 0x10/0x14/0x18/0x1C alias the backdrop entries below them
  function automatic logic [PAL_AW-1:0] pal_index(input logic [VA_W-1:0] a);
    logic [PAL_AW-1:0] i;
    i = a[PAL_AW-1:0];
    if (i[1:0] == 2'b00 && i[4]) begin
      i[4] = 1'b0;
    end
    return i;
  endfunction

  vrp_vram u_vram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (vreq),
    .rdata (vram_rdata),
    .busy  (vram_busy)
  );

  // Handshakes
  assign in_ch.ready  = ~vram_busy & (~out_valid_r | out_ch.ready);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign sel       = in_ch.data.reg_select;
  assign d         = in_ch.data.write_data;
  assign vaddr     = cur_r[VA_W-1:0];
  assign pal_hit   = (vaddr >= PAL_BASE);
  assign pal_idx   = pal_index(vaddr);
  assign cur_inc   = cur_r + (ctrl_r[2] ? VADDR_W'(32) : VADDR_W'(1));
  assign spr_rdata = spr_ok_r ? spr_q_r : 8'h00;

  // Next state for one transfer
  always_comb begin
    ctrl_nxt        = ctrl_r;
    mask_nxt        = mask_r;
    vblank_nxt      = vblank_r;
    toggle_nxt      = toggle_r;
    tmp_nxt         = tmp_r;
    cur_nxt         = cur_r;
    fine_x_nxt      = fine_x_r;
    spr_addr_nxt    = spr_addr_r;
    bus_nxt         = bus_r;
    pal_we          = 1'b0;
    spr_we          = 1'b0;
    vreq            = '0;
    vreq.addr       = vaddr;
    vreq.wdata      = d;
    vreq.mirror_vertical = mirror_r;
    if (in_acc) begin
      unique case (in_ch.data.opcode)
        OP_READ: begin
          unique case (sel)
            REG_STATUS: begin
              bus_nxt    = {vblank_r, 2'b00, bus_r[4:0]};
              vblank_nxt = 1'b0;
              toggle_nxt = 1'b0;
            end
            REG_SPR_DATA: begin
              bus_nxt = spr_rdata;
            end
            REG_DATA: begin
              // Palette returns at once; buffer refills from the nametable below
              if (pal_hit) begin
                bus_nxt   = pal_r[pal_idx];
                vreq.addr = vaddr & NT_MIRROR_MASK;
              end else begin
                bus_nxt = vram_rdata;
              end
              vreq.rd_en = 1'b1;
              cur_nxt    = cur_inc;
            end
            default: ;
          endcase
        end
        OP_WRITE: begin
          bus_nxt = d;
          unique case (sel)
            REG_CTRL: begin
              ctrl_nxt = d;
              tmp_nxt  = {tmp_r[14:12], d[1:0], tmp_r[9:0]};
            end
            REG_MASK: begin
              mask_nxt = d;
            end
            REG_SPR_ADDR: begin
              spr_addr_nxt = d;
            end
            REG_SPR_DATA: begin
              spr_we       = 1'b1;
              spr_addr_nxt = spr_addr_r + 1'b1;
            end
            REG_SCROLL: begin
              if (!toggle_r) begin
                fine_x_nxt = d[2:0];
                tmp_nxt    = {tmp_r[14:5], d[7:3]};
              end else begin
                tmp_nxt = {d[2:0], tmp_r[11:10], d[7:3], tmp_r[4:0]};
              end
              toggle_nxt = ~toggle_r;
            end
            REG_ADDR: begin
              if (!toggle_r) begin
                tmp_nxt = {1'b0, d[5:0], tmp_r[7:0]};
              end else begin
                tmp_nxt = {tmp_r[14:8], d};
                cur_nxt = {tmp_r[14:8], d};
              end
              toggle_nxt = ~toggle_r;
            end
            REG_DATA: begin
              if (pal_hit) begin
                pal_we = 1'b1;
              end else begin
                vreq.wr_en = 1'b1;
              end
              cur_nxt = cur_inc;
            end
            default: ;
          endcase
        end
        OP_VBL_SET: vblank_nxt = 1'b1;
        OP_VBL_CLR: vblank_nxt = 1'b0;
      endcase
    end

    out_nxt.read_data     = bus_nxt;
    out_nxt.current_addr  = cur_nxt;
    out_nxt.temp_addr     = tmp_nxt;
    out_nxt.fine_scroll_x = fine_x_nxt;
    out_nxt.control_value = ctrl_nxt;
    out_nxt.mask_value    = mask_nxt;
    out_nxt.vblank_flag   = vblank_nxt;
    out_nxt.second_write  = toggle_nxt;
  end

  // Control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      mask_r      <= '0;
      vblank_r    <= 1'b0;
      toggle_r    <= 1'b0;
      tmp_r       <= '0;
      cur_r       <= '0;
      fine_x_r    <= '0;
      spr_addr_r  <= '0;
      bus_r       <= '0;
      mirror_r    <= 1'b0;
      spr_vld_r   <= '0;
      spr_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PAL_BYTES; i++) begin
        pal_r[i] <= '0;
      end
    end else begin
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      vblank_r   <= vblank_nxt;
      toggle_r   <= toggle_nxt;
      tmp_r      <= tmp_nxt;
      cur_r      <= cur_nxt;
      fine_x_r   <= fine_x_nxt;
      spr_addr_r <= spr_addr_nxt;
      bus_r      <= bus_nxt;
      if (cfg_ch.valid) begin
        mirror_r <= cfg_ch.data.mirror_vertical;
      end
      if (pal_we) begin
        pal_r[pal_idx] <= d;
      end
      if (spr_we) begin
        spr_vld_r[spr_addr_r] <= 1'b1;
      end
      // Sprite byte at the next address is always staged for a data read
      spr_ok_r <= spr_vld_r[spr_addr_nxt];
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sprite memory: write at the current address, prefetch the next one
  always_ff @(posedge clk) begin
    if (spr_we) begin
      spr_mem[spr_addr_r] <= d;
    end
    spr_q_r <= spr_mem[spr_addr_nxt];
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  // Checks
  `VRP_ASSERT_IMP(a_no_take_in_clear, vram_busy, !in_ch.ready, "item taken during clear sweep")
  `VRP_ASSERT_NXT(a_status_clears, in_acc && in_ch.data.opcode == OP_READ && sel == REG_STATUS, !vblank_r && !toggle_r, "status read did not clear vblank and toggle")
  `VRP_ASSERT_NXT(a_addr_copy, in_acc && in_ch.data.opcode == OP_WRITE && sel == REG_ADDR && toggle_r, cur_r == tmp_r, "second address write did not load current address")
  `VRP_ASSERT_NXT(a_out_tracks, in_acc, out_r.current_addr == cur_r && out_r.read_data == bus_r, "result register out of step with state")

endmodule

// ===== hdl/vrp_vram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_vram
// Pattern and mirrored nametable RAM with registered reads and a clearing
// pass after reset that zeroes both arrays, one entry per cycle.
// ----------------------------------------------------------------------------
module vrp_vram
  import vrp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  vrp_vram_req_t req,
  output logic [7:0]    rdata,
  output logic          busy
);

  logic [7:0]        pat_mem [PAT_BYTES];
  logic [7:0]        nt_mem  [NT_BYTES];
  logic [7:0]        pat_q_r;
  logic [7:0]        nt_q_r;
  logic              nt_sel_r;
  logic              rd_seen_r;
  logic [PAT_AW-1:0] clr_idx_r;
  logic              clr_busy_r;

  logic              is_pat;
  logic [NT_AW-1:0]  nt_idx;
  logic              pat_we;
  logic              nt_we;
  logic [PAT_AW-1:0] pat_waddr;
  logic [NT_AW-1:0]  nt_waddr;
  logic [7:0]        mem_wdata;

  // Fold the nametable window onto 2 KiB: 0x3000 mirrors land on 0x2000
  function automatic logic [NT_AW-1:0] nt_index(input logic [VA_W-1:0] a,
                                                input logic mv);
    logic [11:0] off;
    off = a[11:0];
    return mv ? off[NT_AW-1:0] : {off[11], off[9:0]};
  endfunction

  // Decode the request
  always_comb begin
    is_pat    = (req.addr <= PAT_LAST);
    nt_idx    = nt_index(req.addr, req.mirror_vertical);
    pat_we    = clr_busy_r | (req.wr_en & is_pat);
    nt_we     = clr_busy_r | (req.wr_en & ~is_pat);
    pat_waddr = clr_busy_r ? clr_idx_r : req.addr[PAT_AW-1:0];
    nt_waddr  = clr_busy_r ? clr_idx_r[NT_AW-1:0] : nt_idx;
    mem_wdata = clr_busy_r ? 8'h00 : req.wdata;
  end

  // Pattern memory
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= mem_wdata;
    end
    if (req.rd_en && is_pat) begin
      pat_q_r <= pat_mem[req.addr[PAT_AW-1:0]];
    end
  end

  // Nametable memory
  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[nt_waddr] <= mem_wdata;
    end
    if (req.rd_en && !is_pat) begin
      nt_q_r <= nt_mem[nt_idx];
    end
  end

  // Read select and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nt_sel_r   <= 1'b0;
      rd_seen_r  <= 1'b0;
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      if (req.rd_en) begin
        nt_sel_r  <= ~is_pat;
        rd_seen_r <= 1'b1;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // Read buffer is zero until the first fill
  assign rdata = !rd_seen_r ? 8'h00 : (nt_sel_r ? nt_q_r : pat_q_r);
  assign busy  = clr_busy_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the video register port: a directed table of
// register accesses, then random access sequences across mirroring modes,
// each result compared field by field with a local shadow of the port.
// ----------------------------------------------------------------------------
module tb
  import vrp_pkg::*;
();

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 350;
  localparam int RANDOM_PHASES = 5;
  localparam int PROBES        = 24;

  // Directed access with an optional hand-derived read_data
  typedef struct packed {
    vrp_op_t    op;
    vrp_reg_t   sel;
    logic [7:0] wd;
    logic       known;
    logic [7:0] rd;
  } probe_t;

  probe_t probes [PROBES] = '{
    '{OP_READ,    REG_STATUS,   8'h00, 1'b1, 8'h00},
    '{OP_VBL_SET, REG_CTRL,     8'h00, 1'b0, 8'h00},
    '{OP_READ,    REG_STATUS,   8'h00, 1'b1, 8'h80},
    '{OP_READ,    REG_STATUS,   8'h00, 1'b1, 8'h00},
    '{OP_WRITE,   REG_CTRL,     8'hFF, 1'b1, 8'hFF},
    '{OP_WRITE,   REG_CTRL,     8'h00, 1'b1, 8'h00},
    '{OP_WRITE,   REG_MASK,     8'hFF, 1'b1, 8'hFF},
    '{OP_WRITE,   REG_STATUS,   8'hA5, 1'b1, 8'hA5},
    '{OP_READ,    REG_STATUS,   8'h00, 1'b1, 8'h05},
    '{OP_READ,    REG_CTRL,     8'h00, 1'b1, 8'h05},
    '{OP_WRITE,   REG_SPR_ADDR, 8'hFF, 1'b1, 8'hFF},
    '{OP_WRITE,   REG_SPR_DATA, 8'h5A, 1'b1, 8'h5A},
    '{OP_WRITE,   REG_SPR_ADDR, 8'hFF, 1'b1, 8'hFF},
    '{OP_READ,    REG_SPR_DATA, 8'h00, 1'b1, 8'h5A},
    '{OP_WRITE,   REG_SCROLL,   8'hFF, 1'b0, 8'h00},
    '{OP_WRITE,   REG_SCROLL,   8'h00, 1'b0, 8'h00},
    '{OP_WRITE,   REG_ADDR,     8'h3F, 1'b0, 8'h00},
    '{OP_WRITE,   REG_ADDR,     8'h10, 1'b0, 8'h00},
    '{OP_WRITE,   REG_DATA,     8'h77, 1'b0, 8'h00},
    '{OP_WRITE,   REG_ADDR,     8'h3F, 1'b0, 8'h00},
    '{OP_WRITE,   REG_ADDR,     8'h00, 1'b0, 8'h00},
    '{OP_READ,    REG_DATA,     8'h00, 1'b1, 8'h77},
    '{OP_READ,    REG_ADDR,     8'h00, 1'b0, 8'h00},
    '{OP_VBL_CLR, REG_MASK,     8'h00, 1'b0, 8'h00}
  };

  logic clk;
  logic rst_n;

  vrp_chan_if #(.payload_t(vrp_in_t))  in_ch ();
  vrp_chan_if #(.payload_t(vrp_out_t)) out_ch ();
  vrp_chan_if #(.payload_t(vrp_cfg_t)) cfg_ch ();

  video_register_port dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the port state
  logic               mirror_v_sh;
  logic [7:0]         ctrl_sh;
  logic [7:0]         mask_sh;
  logic               vbl_sh;
  logic               toggle_sh;
  logic [VADDR_W-1:0] temp_sh;
  logic [VADDR_W-1:0] cur_sh;
  logic [2:0]         fine_sh;
  logic [7:0]         spr_addr_sh;
  logic [7:0]         bus_sh;
  logic [7:0]         rdbuf_sh;
  logic [7:0]         spr_sh [SPR_BYTES];
  logic [7:0]         nt_sh  [NT_BYTES];
  logic [7:0]         pal_sh [PAL_BYTES];
  logic [7:0]         pat_sh [PAT_BYTES];

  vrp_out_t pending_views [$];

  int  cycles;
  int  items_sent;
  int  results_seen;
  int  fail_count;
  int  mirror_writes;
  int  stall_left;
  bit  quiet;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
  end

  // Nametable slot after mirroring; 0x3000..0x3EFF folds onto 0x2000..0x2EFF
  function automatic logic [NT_AW-1:0] nt_slot(logic [VA_W-1:0] a);
    if (mirror_v_sh)
      return a[10:0];
    return {a[11], a[9:0]};
  endfunction

  // Palette slot; backdrop entries of the sprite half alias the background half
  function automatic logic [PAL_AW-1:0] pal_slot(logic [VA_W-1:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[1:0] == 2'b00)
      i[4] = 1'b0;
    return i;
  endfunction

  function automatic logic [7:0] vram_byte(logic [VA_W-1:0] a);
    if (a <= PAT_LAST)
      return pat_sh[a[12:0]];
    else if (a < PAL_BASE)
      return nt_sh[nt_slot(a)];
    return pal_sh[pal_slot(a)];
  endfunction

  function automatic logic [VADDR_W-1:0] stepped_addr();
    return cur_sh + (ctrl_sh[2] ? 15'd32 : 15'd1);
  endfunction

  // Apply one access to the shadow and return the port view after it
  function automatic vrp_out_t apply_access(vrp_in_t it);
    vrp_out_t        v;
    logic [7:0]      d;
    logic [7:0]      r;
    logic [VA_W-1:0] a;
    d = it.write_data;
    a = cur_sh[VA_W-1:0];
    case (it.opcode)
      OP_READ: begin
        case (it.reg_select)
          REG_STATUS: begin
            bus_sh    = {vbl_sh, 2'b00, bus_sh[4:0]};
            vbl_sh    = 1'b0;
            toggle_sh = 1'b0;
          end
          REG_SPR_DATA: bus_sh = spr_sh[spr_addr_sh];
          REG_DATA: begin
            // palette returns at once, buffer takes the nametable byte below
            if (a >= PAL_BASE) begin
              r        = vram_byte(a);
              rdbuf_sh = vram_byte(a & NT_MIRROR_MASK);
            end else begin
              r        = rdbuf_sh;
              rdbuf_sh = vram_byte(a);
            end
            cur_sh = stepped_addr();
            bus_sh = r;
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        bus_sh = d;
        case (it.reg_select)
          REG_CTRL: begin
            ctrl_sh        = d;
            temp_sh[11:10] = d[1:0];
          end
          REG_MASK:     mask_sh = d;
          REG_SPR_ADDR: spr_addr_sh = d;
          REG_SPR_DATA: begin
            spr_sh[spr_addr_sh] = d;
            spr_addr_sh         = spr_addr_sh + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle_sh) begin
              fine_sh      = d[2:0];
              temp_sh[4:0] = d[7:3];
            end else begin
              temp_sh[14:12] = d[2:0];
              temp_sh[9:5]   = d[7:3];
            end
            toggle_sh = ~toggle_sh;
          end
          REG_ADDR: begin
            if (!toggle_sh) begin
              temp_sh = {1'b0, d[5:0], temp_sh[7:0]};
            end else begin
              temp_sh[7:0] = d;
              cur_sh       = temp_sh;
            end
            toggle_sh = ~toggle_sh;
          end
          REG_DATA: begin
            if (a <= PAT_LAST)
              pat_sh[a[12:0]] = d;
            else if (a < PAL_BASE)
              nt_sh[nt_slot(a)] = d;
            else
              pal_sh[pal_slot(a)] = d;
            cur_sh = stepped_addr();
          end
          default: ;
        endcase
      end
      OP_VBL_SET: vbl_sh = 1'b1;
      default:    vbl_sh = 1'b0;
    endcase
    v.read_data     = bus_sh;
    v.current_addr  = cur_sh;
    v.temp_addr     = temp_sh;
    v.fine_scroll_x = fine_sh;
    v.control_value = ctrl_sh;
    v.mask_value    = mask_sh;
    v.vblank_flag   = vbl_sh;
    v.second_write  = toggle_sh;
    return v;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10)
      $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Transfer one access; hold valid high across back-to-back transfers
  task automatic send_access(vrp_op_t op, vrp_reg_t sel, logic [7:0] wd,
                             bit known = 1'b0, logic [7:0] rd = 8'h00);
    int       gap;
    vrp_in_t  it;
    vrp_out_t v;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.opcode     = op;
    it.reg_select = sel;
    it.write_data = wd;
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    v = apply_access(it);
    if (known)
      v.read_data = rd;
    pending_views.push_back(v);
    items_sent++;
  endtask

  task automatic program_mirroring(logic vertical);
    vrp_cfg_t c;
    c.mirror_vertical = vertical;
    cfg_ch.data  <= c;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    mirror_v_sh = vertical;
    mirror_writes++;
  endtask

  // Drop valid, wait until every expected result has come back, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_views.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Point the video address somewhere, then a burst of data reads and writes
  task automatic video_burst();
    logic [7:0] hi;
    int         n;
    case ($urandom_range(0, 3))
      0:       hi = 8'($urandom_range(8'h00, 8'h1F));
      1:       hi = 8'($urandom_range(8'h20, 8'h3E));
      2:       hi = 8'h3F;
      default: hi = 8'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0)
      send_access(OP_WRITE, REG_CTRL, 8'($urandom));
    send_access(OP_READ, REG_STATUS, 8'($urandom));
    send_access(OP_WRITE, REG_ADDR, hi);
    send_access(OP_WRITE, REG_ADDR, 8'($urandom));
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 1))
        send_access(OP_WRITE, REG_DATA, 8'($urandom));
      else
        send_access(OP_READ, REG_DATA, 8'($urandom));
    end
  endtask

  task automatic scroll_pair();
    if ($urandom_range(0, 9) < 7)
      send_access(OP_READ, REG_STATUS, 8'($urandom));
    send_access(OP_WRITE, REG_SCROLL, 8'($urandom));
    send_access(OP_WRITE, REG_SCROLL, 8'($urandom));
  endtask

  task automatic sprite_burst();
    logic [7:0] base;
    int         n;
    base = $urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF)) : 8'($urandom);
    send_access(OP_WRITE, REG_SPR_ADDR, base);
    n = $urandom_range(1, 8);
    repeat (n)
      send_access(OP_WRITE, REG_SPR_DATA, 8'($urandom));
    send_access(OP_WRITE, REG_SPR_ADDR, base + 8'($urandom_range(0, n)));
    send_access(OP_READ, REG_SPR_DATA, 8'($urandom));
  endtask

  task automatic vblank_cycle();
    send_access(OP_VBL_SET, vrp_reg_t'($urandom_range(0, 7)), 8'($urandom));
    if ($urandom_range(0, 1))
      send_access(OP_READ, REG_STATUS, 8'($urandom));
    if ($urandom_range(0, 1))
      send_access(OP_VBL_CLR, vrp_reg_t'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic stray_accesses();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      send_access(vrp_op_t'($urandom_range(0, 3)), vrp_reg_t'($urandom_range(0, 7)),
                  8'($urandom));
  endtask

  task automatic run_random(int count);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        video_burst();
      else if (r < 52)
        scroll_pair();
      else if (r < 66)
        sprite_burst();
      else if (r < 76) begin
        send_access(OP_WRITE, REG_CTRL, 8'($urandom));
        send_access(OP_WRITE, REG_MASK, 8'($urandom));
        send_access(OP_READ, vrp_reg_t'($urandom_range(0, 7)), 8'($urandom));
      end else if (r < 86)
        vblank_cycle();
      else
        stray_accesses();
    end
  endtask

  // Result side: random stalls, check each transfer against the oldest view
  always @(posedge clk) begin
    vrp_out_t got;
    vrp_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (pending_views.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = pending_views.pop_front();
          if (got.read_data !== want.read_data)
            note_failure($sformatf("result %0d read_data: expected %h, got %h",
                                   results_seen, want.read_data, got.read_data));
          if (got.current_addr !== want.current_addr)
            note_failure($sformatf("result %0d current_addr: expected %h, got %h",
                                   results_seen, want.current_addr, got.current_addr));
          if (got.temp_addr !== want.temp_addr)
            note_failure($sformatf("result %0d temp_addr: expected %h, got %h",
                                   results_seen, want.temp_addr, got.temp_addr));
          if (got.fine_scroll_x !== want.fine_scroll_x)
            note_failure($sformatf("result %0d fine_scroll_x: expected %h, got %h",
                                   results_seen, want.fine_scroll_x, got.fine_scroll_x));
          if (got.control_value !== want.control_value)
            note_failure($sformatf("result %0d control_value: expected %h, got %h",
                                   results_seen, want.control_value, got.control_value));
          if (got.mask_value !== want.mask_value)
            note_failure($sformatf("result %0d mask_value: expected %h, got %h",
                                   results_seen, want.mask_value, got.mask_value));
          if (got.vblank_flag !== want.vblank_flag)
            note_failure($sformatf("result %0d vblank_flag: expected %b, got %b",
                                   results_seen, want.vblank_flag, got.vblank_flag));
          if (got.second_write !== want.second_write)
            note_failure($sformatf("result %0d second_write: expected %b, got %b",
                                   results_seen, want.second_write, got.second_write));
        end
      end
      // Drop ready for a random stretch now and then
      if (quiet || stall_left == 0) begin
        out_ch.ready <= 1'b1;
        if (!quiet)
          stall_left = idle_len();
      end else begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycles, pending_views.size());
      $display("[video_register_port] ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    cycles        = 0;
    items_sent    = 0;
    results_seen  = 0;
    fail_count    = 0;
    mirror_writes = 0;
    quiet         = 1'b0;
    mirror_v_sh   = 1'b0;
    ctrl_sh       = '0;
    mask_sh       = '0;
    vbl_sh        = 1'b0;
    toggle_sh     = 1'b0;
    temp_sh       = '0;
    cur_sh        = '0;
    fine_sh       = '0;
    spr_addr_sh   = '0;
    bus_sh        = '0;
    rdbuf_sh      = '0;
    foreach (spr_sh[i]) spr_sh[i] = 8'h00;
    foreach (nt_sh[i])  nt_sh[i]  = 8'h00;
    foreach (pal_sh[i]) pal_sh[i] = 8'h00;
    foreach (pat_sh[i]) pat_sh[i] = 8'h00;

    // Hold reset, then release it; the clearing sweep stalls the first access
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_mirroring(1'b0);

    // Directed table
    foreach (probes[i])
      send_access(probes[i].op, probes[i].sel, probes[i].wd, probes[i].known, probes[i].rd);

    // Random phases, alternating mirroring; one phase runs with no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      quiet = (p == 2);
      program_mirroring(p % 2 == 0);
      run_random(PHASE_ITEMS);
    end
    settle();

    $display("covered %0d accesses (%0d directed) over %0d mirroring writes, %0d results",
             items_sent, PROBES, mirror_writes, results_seen);
    if (fail_count == 0 && pending_views.size() == 0)
      $display("[video_register_port] OK");
    else begin
      $display("%0d mismatches, %0d results never arrived", fail_count,
               pending_views.size());
      $display("[video_register_port] ERROR");
    end
    $finish;
  end

endmodule
